[rtl/three_level_persistent_alarm_assert.svh]
// Assertion macros for the alarm block's top-level RTL file.
`ifndef THREE_LEVEL_PERSISTENT_ALARM_ASSERT_SVH
`define THREE_LEVEL_PERSISTENT_ALARM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TLPA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLPA_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tlpa_pkg.sv]
// Types, codes and compare helper for the three-level persistent alarm.
package tlpa_pkg;

	localparam int LEVELS = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RELATION_CODES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIOUS_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMON_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIOUS_HOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMON_HOLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_HOLD = 3'd6;

	// Relation codes; the remaining codes always match.
	localparam logic [2:0] REL_GT = 3'd0;
	localparam logic [2:0] REL_LT = 3'd1;
	localparam logic [2:0] REL_EQ = 3'd2;
	localparam logic [2:0] REL_GE = 3'd3;
	localparam logic [2:0] REL_LE = 3'd4;
	localparam logic [2:0] REL_NE = 3'd5;

	// Raised level codes.
	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_SERIOUS = 2'd1;
	localparam logic [1:0] LVL_COMMON = 2'd2;
	localparam logic [1:0] LVL_WARN = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef struct packed {
		logic [5:0] node_index;
		logic signed [31:0] sample_value;
		logic [31:0] now_secs;
	} in_item_t;

	typedef struct packed {
		logic [1:0] raised_level;
		logic [2:0] cancel_mask;
		logic [2:0] active_mask;
	} out_item_t;

	// Index 0 is serious, 1 common, 2 warn.
	typedef struct packed {
		logic [8:0] relation_codes;
		logic [LEVELS-1:0][31:0] threshold;
		logic [LEVELS-1:0][15:0] hold_secs;
	} cfg_t;

	// One memory entry per node.
	typedef struct packed {
		logic [LEVELS-1:0] running;
		logic [LEVELS-1:0] active;
		logic [LEVELS-1:0][31:0] start_time;
	} entry_t;

	function automatic logic rel_match(input logic [2:0] code, input logic [31:0] a,
		input logic [31:0] b);
		logic gt;
		logic eq;
		logic res;
		gt = $signed(a) > $signed(b);
		eq = a == b;
		unique case (code)
			REL_GT: res = gt;
			REL_LT: res = !gt && !eq;
			REL_EQ: res = eq;
			REL_GE: res = gt || eq;
			REL_LE: res = !gt;
			REL_NE: res = !eq;
			default: res = 1'b1;
		endcase
		return res;
	endfunction

endpackage

[rtl/three_level_persistent_alarm.sv]
// Top level of the three-level persistent alarm: control, configuration and node memory.
//
// Samples enter on the sample channel (valid/ready) and each produces exactly one
// result on the result channel (valid/ready). Configuration registers are written
// through cfg_we/cfg_index/cfg_data, one register per cycle, with no wait.
// Per-node state (timer running bits, alarm bits and three start times) lives in
// one synchronous RAM of NODE_COUNT entries. A sample is accepted and its node
// entry is read at that same edge; then, in the busy state and once the output
// register is free, the entry is updated, written back and the result is loaded
// into the output register, which raises result_valid. The block takes no new
// sample while the previous one is in the busy state.
// While a result waits in the output register the block may take one more sample,
// which then holds in the busy state; no further sample is accepted until the
// receiver takes the waiting result.
// After reset the block sweeps the node memory to zero, one entry a cycle, so
// sample_ready stays low until the sweep is done; configuration writes are taken.
// A node index at or above NODE_COUNT leaves state alone and gives an all-zero result.
`include "three_level_persistent_alarm_assert.svh"

module three_level_persistent_alarm #(
	parameter int NODE_COUNT = 64
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input tlpa_pkg::in_item_t sample,
	output logic result_valid,
	input logic result_ready,
	output tlpa_pkg::out_item_t result,
	input logic cfg_we,
	input logic [tlpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlpa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int ENTRY_W = $bits(tlpa_pkg::entry_t);

	tlpa_pkg::state_t state_q;
	tlpa_pkg::state_t state_d;
	tlpa_pkg::cfg_t cfg_q;
	tlpa_pkg::in_item_t item_s1;
	logic in_range_s1;
	logic [NODE_AW-1:0] clr_cnt_q;
	logic clr_last;
	logic accept;
	logic finish;
	logic ram_we;
	logic [NODE_AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	tlpa_pkg::entry_t cur_entry;
	tlpa_pkg::entry_t nxt_entry;
	tlpa_pkg::out_item_t res;
	logic result_valid_q;
	tlpa_pkg::out_item_t result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlpa_pkg::CFG_RELATION_CODES: cfg_q.relation_codes <= cfg_data[8:0];
				tlpa_pkg::CFG_SERIOUS_THRESHOLD: cfg_q.threshold[0] <= cfg_data;
				tlpa_pkg::CFG_COMMON_THRESHOLD: cfg_q.threshold[1] <= cfg_data;
				tlpa_pkg::CFG_WARN_THRESHOLD: cfg_q.threshold[2] <= cfg_data;
				tlpa_pkg::CFG_SERIOUS_HOLD: cfg_q.hold_secs[0] <= cfg_data[15:0];
				tlpa_pkg::CFG_COMMON_HOLD: cfg_q.hold_secs[1] <= cfg_data[15:0];
				tlpa_pkg::CFG_WARN_HOLD: cfg_q.hold_secs[2] <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign accept = sample_valid && sample_ready;
	assign clr_last = clr_cnt_q == NODE_AW'(NODE_COUNT - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlpa_pkg::ST_CLEAR: if (clr_last) state_d = tlpa_pkg::ST_IDLE;
			tlpa_pkg::ST_IDLE: if (accept) state_d = tlpa_pkg::ST_BUSY;
			tlpa_pkg::ST_BUSY: if (finish) state_d = tlpa_pkg::ST_IDLE;
			default: state_d = tlpa_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		sample_ready = 1'b0;
		finish = 1'b0;
		ram_we = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		unique case (state_q)
			tlpa_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			tlpa_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
			end
			tlpa_pkg::ST_BUSY: begin
				finish = !result_valid_q || result_ready;
				ram_we = finish && in_range_s1;
				ram_waddr = NODE_AW'(item_s1.node_index);
				ram_wdata = nxt_entry;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpa_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tlpa_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + NODE_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
			in_range_s1 <= 32'(sample.node_index) < NODE_COUNT;
		end
	end

	tlpa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODE_COUNT),
		.AW(NODE_AW)
	) u_node_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(NODE_AW'(sample.node_index)),
		.rdata(ram_rdata)
	);

	assign cur_entry = ram_rdata;

	tlpa_update u_update (
		.cfg(cfg_q),
		.item(item_s1),
		.in_range(in_range_s1),
		.cur(cur_entry),
		.nxt(nxt_entry),
		.res(res)
	);

	// Output register; it frees while the receiver takes the previous result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`TLPA_ASSERT_NXT(a_accept_then_busy, accept, state_q == tlpa_pkg::ST_BUSY,
		"accepted request did not enter the busy state")
	`TLPA_ASSERT_IMP(a_single_alarm, result_valid, $onehot0(result.active_mask),
		"more than one alarm level active on a node")
	`TLPA_ASSERT_IMP(a_cancel_not_active, result_valid,
		(result.cancel_mask & result.active_mask) == 3'b000,
		"a withdrawn level is still reported active")
	`TLPA_ASSERT_IMP(a_raised_is_active,
		result_valid && result.raised_level != tlpa_pkg::LVL_NONE,
		result.active_mask[result.raised_level - 2'd1],
		"raised level missing from the active mask")

endmodule

[rtl/tlpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tlpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/tlpa_update.sv]
// Per-sample level evaluation: turns a node entry and a sample into the new entry and result.
module tlpa_update (
	input tlpa_pkg::cfg_t cfg,
	input tlpa_pkg::in_item_t item,
	input logic in_range,
	input tlpa_pkg::entry_t cur,
	output tlpa_pkg::entry_t nxt,
	output tlpa_pkg::out_item_t res
);

	localparam int L = tlpa_pkg::LEVELS;

	logic [L-1:0] match;
	logic [L-1:0] held;
	logic [L-1:0] run;
	logic [L-1:0] act;
	logic [L-1:0] cancel;
	logic [L-1:0][31:0] start;
	logic [1:0] raised;
	logic done;

	always_comb begin
		for (int l = 0; l < L; l++) begin
			match[l] = tlpa_pkg::rel_match(cfg.relation_codes[3*l +: 3], item.sample_value,
				cfg.threshold[l]);
			held[l] = (item.now_secs - cur.start_time[l]) >= {16'd0, cfg.hold_secs[l]};
		end
	end

	// Levels are walked in priority order; the first matching level ends the walk.
	always_comb begin
		run = cur.running;
		act = cur.active;
		start = cur.start_time;
		cancel = '0;
		raised = tlpa_pkg::LVL_NONE;
		done = 1'b0;
		for (int l = 0; l < L; l++) begin
			if (!done) begin
				if (match[l]) begin
					for (int m = l + 1; m < L; m++) begin
						if (!act[l] && !run[m]) begin
							start[m] = item.now_secs;
							run[m] = 1'b1;
						end
					end
					if (!run[l]) begin
						start[l] = item.now_secs;
						run[l] = 1'b1;
					end else if (held[l] && !act[l]) begin
						for (int m = 0; m < L; m++) begin
							if (m != l && act[m]) begin
								cancel[m] = 1'b1;
								act[m] = 1'b0;
								run[m] = 1'b0;
							end
						end
						raised = 2'(l + 1);
						act[l] = 1'b1;
						run = run & (L'(1) << l);
					end
					done = 1'b1;
				end else begin
					run[l] = 1'b0;
					if (act[l]) begin
						cancel[l] = 1'b1;
						act[l] = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		nxt.running = run;
		nxt.active = act;
		nxt.start_time = start;
		if (in_range) begin
			res.raised_level = raised;
			res.cancel_mask = cancel;
			res.active_mask = act;
		end else begin
			res = '0;
		end
	end

endmodule

[dv/tlpa_alarm_checker.sv]
`timescale 1ns / 1ps
// Checker for the three-level alarm: predicts each result and compares it when it is taken.
module tlpa_alarm_checker #(
	parameter int NODE_COUNT = 64
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input tlpa_pkg::in_item_t sample,
	input logic result_valid,
	input logic result_ready,
	input tlpa_pkg::out_item_t result,
	input logic cfg_we,
	input logic [tlpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int mismatch_count,
	output int alarms_pending
);

	logic [8:0] relation_cfg;
	logic signed [31:0] threshold_cfg [tlpa_pkg::LEVELS];
	logic [15:0] hold_cfg [tlpa_pkg::LEVELS];

	logic [31:0] timer_origin [NODE_COUNT][tlpa_pkg::LEVELS];
	logic [tlpa_pkg::LEVELS-1:0] timer_running [NODE_COUNT];
	logic [tlpa_pkg::LEVELS-1:0] alarm_active [NODE_COUNT];

	tlpa_pkg::out_item_t expected_alarms [$];
	tlpa_pkg::out_item_t due_alarm;
	tlpa_pkg::out_item_t fresh_alarm;

	function automatic logic level_matches(input logic [2:0] code,
		input logic signed [31:0] value, input logic signed [31:0] limit);
		case (code)
			tlpa_pkg::REL_GT: return value > limit;
			tlpa_pkg::REL_LT: return value < limit;
			tlpa_pkg::REL_EQ: return value == limit;
			tlpa_pkg::REL_GE: return value >= limit;
			tlpa_pkg::REL_LE: return value <= limit;
			tlpa_pkg::REL_NE: return value != limit;
			default: return 1'b1;
		endcase
	endfunction

	task automatic predict_alarm_step(input tlpa_pkg::in_item_t req,
		output tlpa_pkg::out_item_t res);
		int node;
		logic [tlpa_pkg::LEVELS-1:0] run;
		logic [tlpa_pkg::LEVELS-1:0] act;
		logic [2:0] cancel;
		logic [1:0] raised;
		logic [31:0] elapsed;
		logic settled;
		node = int'(req.node_index);
		res = '0;
		if (node < NODE_COUNT) begin
			run = timer_running[node];
			act = alarm_active[node];
			raised = tlpa_pkg::LVL_NONE;
			cancel = '0;
			settled = 1'b0;
			for (int lvl = 0; lvl < tlpa_pkg::LEVELS; lvl++) begin
				if (!settled) begin
					if (level_matches(relation_cfg[3*lvl +: 3], req.sample_value,
						threshold_cfg[lvl])) begin
						settled = 1'b1;
						// Lower timers start only while this level holds no alarm.
						for (int m = lvl + 1; m < tlpa_pkg::LEVELS; m++) begin
							if (!act[lvl] && !run[m]) begin
								timer_origin[node][m] = req.now_secs;
								run[m] = 1'b1;
							end
						end
						elapsed = req.now_secs - timer_origin[node][lvl];
						if (!run[lvl]) begin
							timer_origin[node][lvl] = req.now_secs;
							run[lvl] = 1'b1;
						end else if (elapsed >= hold_cfg[lvl] && !act[lvl]) begin
							for (int m = 0; m < tlpa_pkg::LEVELS; m++) begin
								if (m != lvl && act[m]) begin
									cancel[m] = 1'b1;
									act[m] = 1'b0;
									run[m] = 1'b0;
								end
							end
							case (lvl)
								0: raised = tlpa_pkg::LVL_SERIOUS;
								1: raised = tlpa_pkg::LVL_COMMON;
								default: raised = tlpa_pkg::LVL_WARN;
							endcase
							act[lvl] = 1'b1;
							run = run & (3'b001 << lvl);
						end
					end else begin
						run[lvl] = 1'b0;
						if (act[lvl]) begin
							cancel[lvl] = 1'b1;
							act[lvl] = 1'b0;
						end
					end
				end
			end
			timer_running[node] = run;
			alarm_active[node] = act;
			res.raised_level = raised;
			res.cancel_mask = cancel;
			res.active_mask = act;
		end
	endtask

	task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relation_cfg = '0;
			for (int lvl = 0; lvl < tlpa_pkg::LEVELS; lvl++) begin
				threshold_cfg[lvl] = '0;
				hold_cfg[lvl] = '0;
			end
			for (int n = 0; n < NODE_COUNT; n++) begin
				timer_running[n] = '0;
				alarm_active[n] = '0;
				for (int lvl = 0; lvl < tlpa_pkg::LEVELS; lvl++)
					timer_origin[n][lvl] = '0;
			end
			expected_alarms.delete();
			mismatch_count = 0;
			alarms_pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_alarms.size() == 0) begin
					$error("result taken with no request outstanding: %h", result);
					mismatch_count++;
				end else begin
					due_alarm = expected_alarms.pop_front();
					check_field("raised_level", {1'b0, due_alarm.raised_level},
						{1'b0, result.raised_level});
					check_field("cancel_mask", due_alarm.cancel_mask, result.cancel_mask);
					check_field("active_mask", due_alarm.active_mask, result.active_mask);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					tlpa_pkg::CFG_RELATION_CODES: relation_cfg = cfg_data[8:0];
					tlpa_pkg::CFG_SERIOUS_THRESHOLD: threshold_cfg[0] = cfg_data;
					tlpa_pkg::CFG_COMMON_THRESHOLD: threshold_cfg[1] = cfg_data;
					tlpa_pkg::CFG_WARN_THRESHOLD: threshold_cfg[2] = cfg_data;
					tlpa_pkg::CFG_SERIOUS_HOLD: hold_cfg[0] = cfg_data[15:0];
					tlpa_pkg::CFG_COMMON_HOLD: hold_cfg[1] = cfg_data[15:0];
					tlpa_pkg::CFG_WARN_HOLD: hold_cfg[2] = cfg_data[15:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) begin
				predict_alarm_step(sample, fresh_alarm);
				expected_alarms.push_back(fresh_alarm);
			end
			alarms_pending = expected_alarms.size();
		end
	end

endmodule

[dv/tb_three_level_persistent_alarm.sv]
`timescale 1ns / 1ps
// Testbench top for the three-level alarm: clock, reset, stimulus, result stalls and verdict.
module tb_three_level_persistent_alarm;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	// Relation codes beyond the named ones; both always match.
	localparam logic [2:0] REL_ALWAYS = 3'd6;
	localparam logic [2:0] REL_ALWAYS_HI = 3'd7;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 55;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	tlpa_pkg::in_item_t sample;
	logic result_valid;
	logic result_ready;
	tlpa_pkg::out_item_t result;
	logic cfg_we;
	logic [tlpa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tlpa_pkg::CFG_DATA_W-1:0] cfg_data;
	int mismatch_count;
	int alarms_pending;

	logic [31:0] thr_now [tlpa_pkg::LEVELS];
	logic [31:0] clock_secs;
	bit steady;

	three_level_persistent_alarm #(
		.NODE_COUNT(64)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tlpa_alarm_checker #(
		.NODE_COUNT(64)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.alarms_pending(alarms_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [31:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return (int'($urandom_range(0, 64)) - 32) * 65536;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] pick_hold();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 12));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Values cluster around the thresholds so that the compares flip often.
	function automatic logic [31:0] pick_value();
		logic [31:0] base;
		base = thr_now[$urandom_range(0, 2)];
		case ($urandom_range(0, 9))
			0: return Q_MIN;
			1: return Q_MAX;
			2, 3: return $urandom();
			4: return base + 1;
			5: return base - 1;
			6: return base + ($urandom_range(0, 8) << 16);
			7: return base - ($urandom_range(0, 8) << 16);
			default: return base;
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 3);
		if (r < 85)
			return $urandom_range(0, 40);
		if (r < 97)
			return $urandom_range(0, 70000);
		return $urandom();
	endfunction

	task automatic write_reg(input logic [tlpa_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input logic [8:0] codes, input logic [31:0] ts, tc, tw,
		input logic [15:0] hs, hc, hw);
		thr_now[0] = ts;
		thr_now[1] = tc;
		thr_now[2] = tw;
		write_reg(tlpa_pkg::CFG_RELATION_CODES, {23'd0, codes});
		write_reg(tlpa_pkg::CFG_SERIOUS_THRESHOLD, ts);
		write_reg(tlpa_pkg::CFG_COMMON_THRESHOLD, tc);
		write_reg(tlpa_pkg::CFG_WARN_THRESHOLD, tw);
		write_reg(tlpa_pkg::CFG_SERIOUS_HOLD, {16'd0, hs});
		write_reg(tlpa_pkg::CFG_COMMON_HOLD, {16'd0, hc});
		write_reg(tlpa_pkg::CFG_WARN_HOLD, {16'd0, hw});
	endtask

	task automatic push_sample(input logic [5:0] node, input logic [31:0] value,
		input logic [31:0] stamp);
		tlpa_pkg::in_item_t item;
		int gap;
		item.node_index = node;
		item.sample_value = value;
		item.now_secs = stamp;
		clock_secs = stamp;
		gap = draw_gap();
		@(negedge clk);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample <= item;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Stops the request stream and waits until every result has come back.
	task automatic settle_block();
		@(negedge clk);
		sample_valid <= 1'b0;
		do @(posedge clk); while (alarms_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Result side: a fresh stall before each result.
	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			@(negedge clk);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		#2_000_000;
		$display("tb_three_level_persistent_alarm NOT OK");
		$finish;
	end

	initial begin
		int pool [4];
		int sent;
		int run_len;
		logic [5:0] node;
		logic [31:0] value;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		clock_secs = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Serious gt 16.0, common lt -16.0, warn ne 0.
		apply_config({tlpa_pkg::REL_NE, tlpa_pkg::REL_LT, tlpa_pkg::REL_GT}, 32'h0010_0000,
			32'hFFF0_0000, 32'h0, 16'd0, 16'd2, 16'd1);
		// A zero hold still needs a second sample before the alarm rises.
		push_sample(6'd0, Q_MAX, 32'd0);
		push_sample(6'd0, Q_MAX, 32'd0);
		push_sample(6'd0, Q_MIN, 32'd1);
		push_sample(6'd0, Q_MIN, 32'd3);
		push_sample(6'd0, 32'h0, 32'd4);
		push_sample(6'd0, 32'h1, 32'd5);
		push_sample(6'd0, 32'h1, 32'd6);
		// Elapsed time across the wrap of the seconds counter.
		push_sample(6'd63, Q_MAX, 32'hFFFF_FFFE);
		push_sample(6'd63, Q_MAX, 32'd3);
		push_sample(6'd63, 32'h0010_0000, 32'd4);
		push_sample(6'd63, 32'h0010_0001, 32'd5);
		settle_block();

		// Serious eq 5 with the longest hold, common ge 100, warn le -100.
		apply_config({tlpa_pkg::REL_LE, tlpa_pkg::REL_GE, tlpa_pkg::REL_EQ}, 32'd5, 32'd100,
			32'hFFFF_FF9C, 16'hFFFF, 16'd0, 16'd0);
		push_sample(6'd5, 32'd5, 32'd100);
		push_sample(6'd5, 32'd5, 32'd65634);
		push_sample(6'd5, 32'd5, 32'd65635);
		push_sample(6'd5, 32'd100, 32'd65636);
		push_sample(6'd5, 32'd99, 32'd65637);
		push_sample(6'd5, 32'hFFFF_FF9C, 32'd65638);
		push_sample(6'd5, 32'hFFFF_FF9C, 32'd65639);
		settle_block();

		// Serious ne the most negative value; common and warn always match.
		apply_config({REL_ALWAYS_HI, REL_ALWAYS, tlpa_pkg::REL_NE}, Q_MIN, 32'h0, 32'h0,
			16'd0, 16'd0, 16'd0);
		push_sample(6'd42, Q_MIN, 32'd70000);
		push_sample(6'd42, Q_MIN, 32'd70001);
		push_sample(6'd42, 32'h0, 32'd70002);
		push_sample(6'd42, 32'h0, 32'd70003);
		settle_block();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_config(9'h000, Q_MIN, Q_MIN, Q_MIN, 16'd0, 16'd0, 16'd0);
				1: apply_config(9'h1FF, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: apply_config(9'($urandom_range(0, 511)), pick_threshold(),
					pick_threshold(), pick_threshold(), pick_hold(), pick_hold(), pick_hold());
			endcase
			if (phase % 4 == 3)
				clock_secs = 32'hFFFF_FFFF - $urandom_range(0, 300);
			for (int i = 0; i < 4; i++)
				pool[i] = int'($urandom_range(0, 63));
			sent = 0;
			// Runs of samples on one node let timers build up; stray nodes break them.
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					node = 6'(pool[$urandom_range(0, 3)]);
				else
					node = 6'($urandom_range(0, 63));
				run_len = $urandom_range(1, 8);
				value = pick_value();
				for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
					if ($urandom_range(0, 3) == 0)
						value = pick_value();
					push_sample(node, value, clock_secs + pick_step());
					sent++;
				end
				if ($urandom_range(0, 7) == 0)
					steady = !steady;
			end
			settle_block();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_three_level_persistent_alarm OK");
		end else begin
			$display("tb_three_level_persistent_alarm NOT OK");
		end
		$finish;
	end

endmodule
